// File: rtl/core/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg
// Shared constants and controller/datapath command and status types for the
// flag-delimited frame extractor.
// ----------------------------------------------------------------------------
package fde_pkg;

    // Frame delimiter and length-field layout
    localparam logic [7:0]  FLAG_BYTE         = 8'h7E;
    localparam int unsigned LEN_OFFSET        = 2;
    localparam int unsigned LEN_OVERHEAD      = 5;
    localparam int unsigned FRAME_MAX_DEFAULT = 64;

    // Width of the length check: span and length + overhead both fit here
    localparam int unsigned LEN_CMP_W = 9;

    // Output index width, taken modulo 64
    localparam int unsigned INDEX_W = 6;

    // Controller to datapath commands
    typedef struct packed {
        logic open_frame;   // store opening flag, count = 1
        logic store_byte;   // append the input byte
        logic clear_frame;  // drop the open frame
        logic rd_start;     // point read index at entry 0
        logic rd_next;      // advance read index
    } fde_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_flag;      // input byte is the delimiter
        logic len_ok;       // length byte present and length + 5 <= span
        logic room;         // a data byte still leaves room for a closing flag
        logic at_end;       // read index has reached the closing flag slot
    } fde_status_t;

endpackage

// File: rtl/core/fde_if.sv
// ----------------------------------------------------------------------------
// fde_if
// Valid/ready channels of the frame extractor: received bytes in, frame
// bytes out.
// ----------------------------------------------------------------------------
interface fde_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fde_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       last;

    modport source (output valid, output frame_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input last, output ready);
endinterface

// File: rtl/core/fde_ctrl.sv
// ----------------------------------------------------------------------------
// fde_ctrl
// Controller: hunts for a flag, collects a frame, then replays an accepted
// frame one beat at a time from the frame store.
// ----------------------------------------------------------------------------
module fde_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_ready,
    output logic                 frame_valid,
    input  logic                 frame_ready,
    input  fde_pkg::fde_status_t status,
    output fde_pkg::fde_cmd_t    cmd
);
    import fde_pkg::*;

    typedef enum logic [3:0] {
        ST_HUNT  = 4'b0001,
        ST_FRAME = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rx_fire;
    logic   frame_fire;

    assign rx_ready    = (state_reg == ST_HUNT) || (state_reg == ST_FRAME);
    assign frame_valid = (state_reg == ST_SEND);
    assign rx_fire     = rx_valid && rx_ready;
    assign frame_fire  = frame_valid && frame_ready;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT:
            begin
                if (rx_fire && status.is_flag)
                begin
                    cmd.open_frame = 1'b1;
                    state_next     = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (rx_fire)
                begin
                    if (status.is_flag)
                    begin
                        if (status.len_ok)
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = ST_FETCH;
                        end
                        else
                        begin
                            // early flag opens a new frame
                            cmd.open_frame = 1'b1;
                        end
                    end
                    else if (status.room)
                    begin
                        cmd.store_byte = 1'b1;
                    end
                    else
                    begin
                        // frame too long: drop and hunt
                        cmd.clear_frame = 1'b1;
                        state_next      = ST_HUNT;
                    end
                end
            end
            ST_FETCH:
            begin
                // store read lands in the read register this cycle
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (frame_fire)
                begin
                    if (status.at_end)
                    begin
                        cmd.clear_frame = 1'b1;
                        state_next      = ST_HUNT;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/fde_datapath.sv
// ----------------------------------------------------------------------------
// fde_datapath
// Frame store, byte count, length field and replay index, with the frame
// acceptance check.
// ----------------------------------------------------------------------------
module fde_datapath
#(
    parameter int unsigned FRAME_MAX = fde_pkg::FRAME_MAX_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  fde_pkg::fde_cmd_t    cmd,
    output fde_pkg::fde_status_t status,
    output logic [7:0]           frame_byte,
    output logic [5:0]           byte_index,
    output logic                 last
);
    import fde_pkg::*;

    localparam int unsigned ADDR_W = $clog2(FRAME_MAX);

    logic [7:0]        mem [FRAME_MAX];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] count_reg;
    logic [ADDR_W-1:0] count_next;
    logic [7:0]        len_reg;
    logic [7:0]        len_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [LEN_CMP_W-1:0] span;
    logic [LEN_CMP_W-1:0] need;
    logic [ADDR_W+INDEX_W-1:0] idx_ext;

    // Acceptance check and status
    assign span = LEN_CMP_W'(count_reg) + LEN_CMP_W'(1);
    assign need = LEN_CMP_W'(len_reg) + LEN_CMP_W'(LEN_OVERHEAD);

    assign status.is_flag = (rx_byte == FLAG_BYTE);
    assign status.len_ok  = (count_reg > ADDR_W'(LEN_OFFSET)) && (need <= span);
    assign status.room    = ({1'b0, count_reg} < (ADDR_W+1)'(FRAME_MAX - 1));
    assign status.at_end  = (idx_reg == count_reg);

    // Store write port
    assign wr_en   = cmd.open_frame || cmd.store_byte;
    assign wr_addr = cmd.open_frame ? '0 : count_reg;
    assign wr_data = cmd.open_frame ? FLAG_BYTE : rx_byte;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // Count, length and replay index
    always_comb
    begin
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        if (cmd.open_frame)
        begin
            count_next = ADDR_W'(1);
            len_next   = '0;
        end
        else if (cmd.store_byte)
        begin
            count_next = count_reg + ADDR_W'(1);
            if (count_reg == ADDR_W'(LEN_OFFSET))
            begin
                len_next = rx_byte;
            end
        end
        else if (cmd.clear_frame)
        begin
            count_next = '0;
            len_next   = '0;
        end
        if (cmd.rd_start)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    // Output beat: closing flag comes from the constant, the rest from the store
    assign idx_ext    = {{INDEX_W{1'b0}}, idx_reg};
    assign last       = status.at_end;
    assign frame_byte = status.at_end ? FLAG_BYTE : rd_data_reg;
    assign byte_index = idx_ext[INDEX_W-1:0];

endmodule

// File: rtl/core/flag_delimited_frame_extractor.sv
// ----------------------------------------------------------------------------
// flag_delimited_frame_extractor
// Extracts 0x7E-delimited frames from a received byte stream and replays
// each accepted frame, flags included, with a last marker.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                             Beat
//  rx       in   rx_byte[7:0]                        one received byte
//  frames   out  frame_byte[7:0] byte_index[5:0]     one frame byte
//                last
//
//  rx is ready while hunting or collecting.
//  An accepted frame is replayed beat by beat, each beat a store read, then
//  output, and a beat can stall on output; rx is held off until the replay
//  ends.
//  Reset clears the count, length and state; the store itself is not reset.
//  frames payload holds steady while valid is high and ready low.
//
module flag_delimited_frame_extractor
#(
    parameter int unsigned FRAME_MAX = fde_pkg::FRAME_MAX_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    fde_rx_if.sink      rx,
    fde_frame_if.source frames
);
    import fde_pkg::*;

    fde_cmd_t    cmd;
    fde_status_t status;

    fde_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx.valid),
        .rx_ready    (rx.ready),
        .frame_valid (frames.valid),
        .frame_ready (frames.ready),
        .status      (status),
        .cmd         (cmd)
    );

    fde_datapath #(
        .FRAME_MAX (FRAME_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx.rx_byte),
        .cmd        (cmd),
        .status     (status),
        .frame_byte (frames.frame_byte),
        .byte_index (frames.byte_index),
        .last       (frames.last)
    );

    // Input and replay never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rx.ready && frames.valid))
        else $error("rx ready while replaying a frame");

    // The last beat carries the closing flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.last) |-> (frames.frame_byte == FLAG_BYTE))
        else $error("last beat is not a flag");

    // After the closing beat the block hunts again
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.ready && frames.last) |=> rx.ready)
        else $error("not hunting after frame end");

    // The store is never written while a replay beat is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        frames.valid |-> !(cmd.open_frame || cmd.store_byte))
        else $error("store written during replay");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flag-delimited frame extractor. Received bytes
// go in on the rx channel and each one is fed to a behavioural deframer. The
// deframer queues the frame beats it expects, and every beat taken from the
// frames channel is compared field by field with the oldest one queued. A
// short directed table comes first, then randomised frames under varying
// back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import fde_pkg::*;

    localparam int unsigned FRAME_MAX      = FRAME_MAX_DEFAULT;
    // A long receiver hold is the slowest quiet stretch; allow several times it
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned ITEMS_PER_RUN  = 107;
    localparam int          FROM_PREDICTOR = -1;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_index;
        logic       last;
    } frame_beat_t;

    // typed_beats: number of beats read straight off the byte, or FROM_PREDICTOR
    typedef struct packed {
        logic [7:0] rx_byte;
        int         typed_beats;
    } dir_row_t;

    typedef enum int {
        FK_GOOD,
        FK_EARLY,
        FK_SHORT,
        FK_NOISE,
        FK_LONGEST,
        FK_OVERLONG
    } frame_kind_t;

    localparam dir_row_t DIRECTED_ROWS [21] = '{
        '{8'h00, 0},                        // hunting, ignored
        '{8'hFF, 0},                        // hunting, ignored
        '{FLAG_BYTE, 0},                    // opening flag
        '{FLAG_BYTE, 0},                    // flag with only the opening flag stored
        '{8'h01, 0},
        '{FLAG_BYTE, 0},                    // flag one byte short of the length
        '{8'hAA, 0},
        '{8'h00, 0},                        // length 0
        '{8'h55, 0},
        '{FLAG_BYTE, FROM_PREDICTOR},       // shortest accepted frame
        '{FLAG_BYTE, 0},                    // opening flag again
        '{8'h12, 0},
        '{8'hFF, 0},                        // length 255
        '{8'h34, 0},
        '{FLAG_BYTE, 0},                    // closing flag too early, reopens
        '{8'h80, 0},
        '{8'h01, 0},                        // length 1, exactly fits
        '{8'h00, 0},
        '{8'hFF, 0},
        '{FLAG_BYTE, FROM_PREDICTOR},       // accepted at the length boundary
        '{8'h11, 0}                         // hunting again after a frame
    };

    logic clk;
    logic rst_n;

    fde_rx_if    rx_ch ();
    fde_frame_if frm_ch ();

    flag_delimited_frame_extractor DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .frames (frm_ch)
    );

    // Deframer state
    logic [7:0]  dfr_store [FRAME_MAX];
    int unsigned dfr_count  = 0;
    bit          dfr_open   = 1'b0;
    logic [7:0]  dfr_length = 8'h00;

    frame_beat_t pending_beats [$];

    int unsigned snd_idle_pct    = 0;
    int unsigned rcv_idle_pct    = 0;
    bit          hold_req        = 1'b0;
    int unsigned error_count     = 0;
    int unsigned bytes_sent      = 0;
    int unsigned active_items    = 0;
    int unsigned beats_checked   = 0;
    int unsigned frames_replayed = 0;
    int unsigned reopen_count    = 0;
    int unsigned drop_count      = 0;
    int unsigned longest_frame   = 0;

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void start_frame_model();
        dfr_store[0] = FLAG_BYTE;
        dfr_count    = 1;
        dfr_length   = 8'h00;
        dfr_open     = 1'b1;
    endfunction

    // Advance the deframer by one received byte; returns 0 if the byte is ignored
    function automatic bit deframe_byte(input logic [7:0] b, ref frame_beat_t beats [$]);
        bit          active;
        int unsigned k;
        active = 1'b1;
        beats.delete();
        if (!dfr_open)
        begin
            if (b == FLAG_BYTE)
                start_frame_model();
            else
                active = 1'b0;
        end
        else if (b == FLAG_BYTE)
        begin
            // span counts the closing flag too
            if (dfr_count > LEN_OFFSET && int'(dfr_length) + LEN_OVERHEAD <= dfr_count + 1)
            begin
                for (k = 0; k < dfr_count; k++)
                    beats.push_back('{frame_byte: dfr_store[k], byte_index: k[5:0],
                                      last: 1'b0});
                beats.push_back('{frame_byte: FLAG_BYTE, byte_index: dfr_count[5:0],
                                  last: 1'b1});
                dfr_open   = 1'b0;
                dfr_count  = 0;
                dfr_length = 8'h00;
                if (beats.size() > longest_frame)
                    longest_frame = beats.size();
            end
            else
            begin
                reopen_count++;
                start_frame_model();
            end
        end
        else if (dfr_count + 1 < FRAME_MAX)
        begin
            dfr_store[dfr_count] = b;
            if (dfr_count == LEN_OFFSET)
                dfr_length = b;
            dfr_count++;
        end
        else
        begin
            // no room left for a closing flag: drop and hunt
            drop_count++;
            dfr_open   = 1'b0;
            dfr_count  = 0;
            dfr_length = 8'h00;
        end
        return active;
    endfunction

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == FLAG_BYTE)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic frame_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return FK_GOOD;
        else if (r < 72)
            return FK_EARLY;
        else if (r < 80)
            return FK_SHORT;
        else if (r < 92)
            return FK_NOISE;
        else if (r < 96)
            return FK_LONGEST;
        return FK_OVERLONG;
    endfunction

    // Offer one byte, wait for the beat to be taken, then predict
    task automatic send_byte(input logic [7:0] b, input bit use_predictor);
        frame_beat_t beats [$];
        bit          active;
        bit          taken;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        // ready is settled by the falling edge; the beat goes at the next rising edge
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (rx_ch.ready === 1'b1);
            @(posedge clk);
        end
        active = deframe_byte(b, beats);
        bytes_sent++;
        if (active)
            active_items++;
        if (use_predictor)
            foreach (beats[i])
                pending_beats.push_back(beats[i]);
    endtask

    task automatic send_frame(input frame_kind_t kind);
        int unsigned n_data;
        logic [7:0]  len_byte;
        case (kind)
            FK_GOOD, FK_LONGEST:
            begin
                if (kind == FK_LONGEST)
                    n_data = FRAME_MAX - 2;
                else if ($urandom_range(3) == 0)
                    n_data = $urandom_range(40, 13);
                else
                    n_data = $urandom_range(12, 3);
                // half the time sit right on the length limit
                if ($urandom_range(1) == 0)
                    len_byte = 8'(n_data - 3);
                else
                    len_byte = 8'($urandom_range(n_data - 3));
                send_byte(FLAG_BYTE, 1'b1);
                send_byte(data_byte(), 1'b1);
                send_byte(len_byte, 1'b1);
                repeat (n_data - 2)
                    send_byte(data_byte(), 1'b1);
                send_byte(FLAG_BYTE, 1'b1);
            end
            FK_EARLY:
            begin
                n_data = $urandom_range(10, 2);
                if ($urandom_range(1) == 0)
                    len_byte = 8'(n_data - 2);
                else
                    len_byte = 8'($urandom_range(255, n_data - 2));
                if (len_byte == FLAG_BYTE)
                    len_byte = 8'hFF;
                send_byte(FLAG_BYTE, 1'b1);
                send_byte(data_byte(), 1'b1);
                send_byte(len_byte, 1'b1);
                repeat (n_data - 2)
                    send_byte(data_byte(), 1'b1);
                send_byte(FLAG_BYTE, 1'b1);
            end
            FK_SHORT:
            begin
                send_byte(FLAG_BYTE, 1'b1);
                repeat ($urandom_range(1))
                    send_byte(data_byte(), 1'b1);
            end
            FK_OVERLONG:
            begin
                send_byte(FLAG_BYTE, 1'b1);
                repeat (FRAME_MAX - 1)
                    send_byte(data_byte(), 1'b1);
                repeat ($urandom_range(2))
                    send_byte(data_byte(), 1'b1);
            end
            default:
            begin
                repeat ($urandom_range(4, 1))
                    send_byte(($urandom_range(7) == 0) ? FLAG_BYTE
                                                       : 8'($urandom_range(255)), 1'b1);
            end
        endcase
    endtask

    // Sender goes quiet until every queued beat has been taken
    task automatic wait_for_drain();
        rx_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_beat();
        frame_beat_t want;
        if (pending_beats.size() == 0)
        begin
            $error("unexpected frame beat: frame_byte %02h byte_index %0d last %0b",
                   frm_ch.frame_byte, frm_ch.byte_index, frm_ch.last);
            error_count++;
            return;
        end
        want = pending_beats.pop_front();
        if (frm_ch.frame_byte !== want.frame_byte)
        begin
            $error("frame_byte: expected %02h, actual %02h", want.frame_byte,
                   frm_ch.frame_byte);
            error_count++;
        end
        if (frm_ch.byte_index !== want.byte_index)
        begin
            $error("byte_index: expected %0d, actual %0d", want.byte_index,
                   frm_ch.byte_index);
            error_count++;
        end
        if (frm_ch.last !== want.last)
        begin
            $error("last: expected %0b, actual %0b", want.last, frm_ch.last);
            error_count++;
        end
        beats_checked++;
        if (want.last)
            frames_replayed++;
    endfunction

    // Frame receiver: random ready, with an occasional long hold-off
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        frm_ch.ready <= 1'b0;
        forever
        begin
            // beat is settled at the falling edge, ahead of the edge that takes it
            @(negedge clk);
            if (frm_ch.valid === 1'b1 && frm_ch.ready === 1'b1)
                check_beat();
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                frm_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                frm_ch.ready <= 1'b0;
            end
            else
                frm_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: quiet cycles on both channels
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
                (frm_ch.valid === 1'b1 && frm_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout after %0d quiet cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned target;
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        snd_idle_pct = 9;
        rcv_idle_pct = 45;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].rx_byte,
                      DIRECTED_ROWS[i].typed_beats == FROM_PREDICTOR);

        // Random frames in three back-pressure settings
        target = 0;
        for (int run = 1; run <= 3; run++)
        begin
            wait_for_drain();
            target += ITEMS_PER_RUN;
            case (run)
                1:
                begin
                    snd_idle_pct = 9;
                    rcv_idle_pct = 45;
                    send_frame(FK_LONGEST);
                end
                2:
                begin
                    snd_idle_pct = 45;
                    rcv_idle_pct = 9;
                    hold_req     = 1'b1;
                    send_frame(FK_GOOD);
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    send_frame(FK_OVERLONG);
                end
            endcase
            while (active_items < target)
                send_frame(pick_kind());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d bytes (%0d not ignored); %0d frames replayed as %0d beats,",
                 bytes_sent, active_items, frames_replayed, beats_checked);
        $display("longest %0d. Flags that reopened a frame: %0d; overlong frames dropped: %0d.",
                 longest_frame, reopen_count, drop_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
